// ----- rtl/i2cbe_pkg.sv -----
// ----------------------------------------------------------------------------
// I2C bit engine package
// Shared types, command codes and sizing constants for the I2C bit engine.
// ----------------------------------------------------------------------------
package i2cbe_pkg;

  // Command codes as they arrive in the command field
  localparam logic [1:0] CMD_START = 2'd0;
  localparam logic [1:0] CMD_STOP  = 2'd1;
  localparam logic [1:0] CMD_WRITE = 2'd2;
  localparam logic [1:0] CMD_READ  = 2'd3;

  // Item kinds on the input tuser bit
  localparam logic KIND_CMD  = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  // Phase numbers within a command
  localparam logic [4:0] PH_WR_ACK_SETUP  = 5'd16;
  localparam logic [4:0] PH_WR_ACK_SAMPLE = 5'd17;
  localparam logic [4:0] PH_RD_BITS_END   = 5'd16;
  localparam logic [4:0] PH_RD_ACK_DRIVE  = 5'd17;
  localparam logic [4:0] PH_RD_ACK_HIGH   = 5'd18;
  localparam logic [4:0] PH_RD_ACK_LOW    = 5'd19;

  // Default depth of the queue between front and back (power of two, >= 2)
  localparam int QUEUE_DEPTH_DEF = 4;

  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 16;

  // Running operation, one-hot
  typedef enum logic [3:0] {
    OP_START = 4'b0001,
    OP_STOP  = 4'b0010,
    OP_WRITE = 4'b0100,
    OP_READ  = 4'b1000
  } op_t;

  // Classified item handed from front to back
  typedef struct packed {
    logic       is_tick;
    op_t        op;
    logic [7:0] tx_byte;
    logic       send_ack;
    logic       sda_sample;
  } item_t;

  // Result fields of one item
  typedef struct packed {
    logic       rejected;
    logic       slave_nack;
    logic [7:0] rx_byte;
    logic       done_res;
    logic       busy_res;
    logic       sda_pull_low;
    logic       scl_pull_low;
  } result_t;

  function automatic op_t decode_cmd(input logic [1:0] cmd);
    op_t op;
    case (cmd)
      CMD_START: op = OP_START;
      CMD_STOP:  op = OP_STOP;
      CMD_WRITE: op = OP_WRITE;
      CMD_READ:  op = OP_READ;
      default:   op = OP_START;
    endcase
    return op;
  endfunction

endpackage

// ----- rtl/i2cbe_front.sv -----
// ----------------------------------------------------------------------------
// I2C bit engine front end
// Accepts input items, classifies them and buffers them in a short queue.
// ----------------------------------------------------------------------------
module i2cbe_front
  import i2cbe_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_TDATA_W-1:0] in_tdata,
  input  logic                  in_tuser,
  output logic                  q_valid,
  input  logic                  q_ready,
  output item_t                 q_item
);

  localparam int PtrW = $clog2(QUEUE_DEPTH);
  localparam int CntW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CntW-1:0] FullCount = CntW'(QUEUE_DEPTH);

  item_t           slots_r [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0] count_r, count_nxt;
  item_t           item_in;
  logic            push, pop;

  // Classify the incoming item
  always_comb begin
    item_in.is_tick    = (in_tuser == KIND_TICK);
    item_in.op         = decode_cmd(in_tdata[1:0]);
    item_in.tx_byte    = in_tdata[9:2];
    item_in.send_ack   = in_tdata[10];
    item_in.sda_sample = in_tdata[11];
  end

  assign in_tready = (count_r != FullCount);
  assign q_valid   = (count_r != '0);
  assign q_item    = slots_r[rd_ptr_r];
  assign push      = in_tvalid && in_tready;
  assign pop       = q_valid && q_ready;

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the item in its slot
  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= item_in;
    end
  end

endmodule

// ----- rtl/i2cbe_back.sv -----
// ----------------------------------------------------------------------------
// I2C bit engine back end
// Runs the command phase schedule one item per cycle while the output is not stalled, and holds the result.
// ----------------------------------------------------------------------------
module i2cbe_back
  import i2cbe_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    q_valid,
  output logic    q_ready,
  input  item_t   q_item,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_res
);

  op_t        op_r, op_nxt;
  logic       running_r, running_nxt;
  logic [4:0] phase_r, phase_nxt;
  logic [7:0] shift_r, shift_nxt;
  logic       ack_r, ack_nxt;
  logic       scl_r, scl_nxt;
  logic       sda_r, sda_nxt;
  logic [7:0] last_rx_r, last_rx_nxt;
  logic       last_nack_r, last_nack_nxt;
  logic       valid_r;
  result_t    res_r, res_nxt;
  logic       fin, rej, take;

  // Take an item whenever the output slot is free or being drained
  assign q_ready   = !valid_r || out_ready;
  assign take      = q_valid && q_ready;
  assign out_valid = valid_r;
  assign out_res   = res_r;

  // Next engine state for the item at the head of the queue
  always_comb begin
    op_nxt        = op_r;
    running_nxt   = running_r;
    phase_nxt     = phase_r;
    shift_nxt     = shift_r;
    ack_nxt       = ack_r;
    scl_nxt       = scl_r;
    sda_nxt       = sda_r;
    last_rx_nxt   = last_rx_r;
    last_nack_nxt = last_nack_r;
    fin           = 1'b0;
    rej           = 1'b0;
    if (!q_item.is_tick) begin
      if (running_r) begin
        rej = 1'b1;
      end else begin
        op_nxt      = q_item.op;
        running_nxt = 1'b1;
        phase_nxt   = '0;
        shift_nxt   = (q_item.op == OP_WRITE) ? q_item.tx_byte : 8'h00;
        ack_nxt     = q_item.send_ack;
      end
    end else if (running_r) begin
      phase_nxt = phase_r + 1'b1;
      case (op_r)
        OP_START: begin
          if (phase_r == 5'd0) begin
            sda_nxt = 1'b0;
            scl_nxt = 1'b0;
          end else if (phase_r == 5'd1) begin
            sda_nxt = 1'b1;
          end else begin
            scl_nxt = 1'b1;
            fin     = 1'b1;
          end
        end
        OP_STOP: begin
          if (phase_r == 5'd0) begin
            sda_nxt = 1'b1;
          end else if (phase_r == 5'd1) begin
            scl_nxt = 1'b0;
          end else begin
            sda_nxt = 1'b0;
            fin     = 1'b1;
          end
        end
        OP_WRITE: begin
          if (phase_r < PH_WR_ACK_SETUP) begin
            // Even phase drives the next bit with SCL low, odd releases SCL
            if (!phase_r[0]) begin
              scl_nxt   = 1'b1;
              sda_nxt   = ~shift_r[7];
              shift_nxt = {shift_r[6:0], 1'b0};
            end else begin
              scl_nxt = 1'b0;
            end
          end else if (phase_r == PH_WR_ACK_SETUP) begin
            scl_nxt = 1'b1;
            sda_nxt = 1'b0;
          end else if (phase_r == PH_WR_ACK_SAMPLE) begin
            scl_nxt       = 1'b0;
            last_nack_nxt = q_item.sda_sample;
          end else begin
            scl_nxt = 1'b1;
            fin     = 1'b1;
          end
        end
        OP_READ: begin
          if (phase_r == 5'd0) begin
            sda_nxt = 1'b0;
            scl_nxt = 1'b1;
          end else if (phase_r <= PH_RD_BITS_END) begin
            // Odd phase samples with SCL released, even pulls SCL low
            if (phase_r[0]) begin
              scl_nxt   = 1'b0;
              shift_nxt = {shift_r[6:0], q_item.sda_sample};
            end else begin
              scl_nxt = 1'b1;
            end
          end else if (phase_r == PH_RD_ACK_DRIVE) begin
            sda_nxt = ack_r;
          end else if (phase_r == PH_RD_ACK_HIGH) begin
            scl_nxt = 1'b0;
          end else if (phase_r == PH_RD_ACK_LOW) begin
            scl_nxt = 1'b1;
          end else begin
            sda_nxt     = 1'b0;
            last_rx_nxt = shift_r;
            fin         = 1'b1;
          end
        end
        default: begin
          fin = 1'b1;
        end
      endcase
      if (fin) begin
        running_nxt = 1'b0;
        phase_nxt   = '0;
      end
    end
  end

  // Assemble the result
  always_comb begin
    res_nxt.scl_pull_low = scl_nxt;
    res_nxt.sda_pull_low = sda_nxt;
    res_nxt.busy_res     = running_nxt;
    res_nxt.done_res     = fin;
    res_nxt.rx_byte      = last_rx_nxt;
    res_nxt.slave_nack   = last_nack_nxt;
    res_nxt.rejected     = rej;
  end

  // Commit state on each taken item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_r        <= OP_START;
      running_r   <= 1'b0;
      phase_r     <= '0;
      shift_r     <= '0;
      ack_r       <= 1'b0;
      scl_r       <= 1'b0;
      sda_r       <= 1'b0;
      last_rx_r   <= '0;
      last_nack_r <= 1'b0;
    end else if (take) begin
      op_r        <= op_nxt;
      running_r   <= running_nxt;
      phase_r     <= phase_nxt;
      shift_r     <= shift_nxt;
      ack_r       <= ack_nxt;
      scl_r       <= scl_nxt;
      sda_r       <= sda_nxt;
      last_rx_r   <= last_rx_nxt;
      last_nack_r <= last_nack_nxt;
    end
  end

  // Hold the result until the receiver takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (q_ready) begin
      valid_r <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res_r <= res_nxt;
    end
  end

endmodule

// ----- rtl/i2c_master_bit_engine_core.sv -----
// ----------------------------------------------------------------------------
// I2C master bit engine
// Open-drain I2C master that runs start, stop, byte write and byte read
// commands, one half-bit phase per tick item.
// ----------------------------------------------------------------------------
// Usage: the input stream carries command items (in_tuser = 0) and tick
// items (in_tuser = 1). A command is taken only while no command runs;
// otherwise it is answered with rejected set. Each tick advances the running
// command by one half-bit phase and supplies the sampled SDA level. Every
// input item yields exactly one result item with the line drives (1 = pull
// low) and status. Start and stop take three ticks, a write nineteen, a read
// twenty-one.
// Path: an accepted item is written to a queue slot, and the back end then
// computes its result into the output register. Throughput: one item per
// cycle while the output is not stalled, set by the phase update in the back end.
// Reset: all lines released, no command running, queue and output empty.
// Stall: the output register holds its result while out_tready is low; the
// queue keeps taking items until its QUEUE_DEPTH entries are full, then
// in_tready drops.
// ----------------------------------------------------------------------------
module i2c_master_bit_engine_core
  import i2cbe_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // command[1:0], tx_byte[9:2], send_ack[10], sda_sample[11], zero fill
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // kind
  input  logic                   in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // scl_pull_low[0], sda_pull_low[1], busy_res[2], done_res[3],
  // rx_byte[11:4], slave_nack[12], rejected[13], zero fill
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  logic    q_valid, q_ready;
  item_t   q_item;
  result_t res;

  i2cbe_front #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata (in_tdata),
    .in_tuser (in_tuser),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_item   (q_item)
  );

  i2cbe_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_item   (q_item),
    .out_valid(out_tvalid),
    .out_ready(out_tready),
    .out_res  (res)
  );

  // Pack result fields, listed from the highest bit down
  assign out_tdata = {2'b00, res.rejected, res.slave_nack, res.rx_byte,
                      res.done_res, res.busy_res, res.sda_pull_low,
                      res.scl_pull_low};

endmodule
